// ===== hdl/xibe_pkg.sv =====
// Package for the x86 instruction byte encoder: payload types, opcode constants
// and small lookup functions.
// Depends on nothing; every other file of the block imports it.
package xibe_pkg;

  // Input item: one resolved instruction.
  typedef struct packed {
    logic [5:0]  operation;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
    logic [15:0] start_offset;
  } in_item_t;

  // Result item: one machine code byte.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_position;
    logic        is_last;
    logic        unknown_op;
  } out_item_t;

  localparam int unsigned MaxBytes = 6;

  // Fully encoded instruction, handed from the encoder to the serialiser.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic [15:0]              start;
    logic                     unknown;
  } enc_t;

  // Variant ids.
  localparam logic [5:0] OpPush    = 6'd0;
  localparam logic [5:0] OpPop     = 6'd1;
  localparam logic [5:0] OpMovBase = 6'd2;
  localparam logic [5:0] OpCmpBase = 6'd8;
  localparam logic [5:0] OpRet     = 6'd14;
  localparam logic [5:0] OpInt     = 6'd15;
  localparam logic [5:0] OpCall    = 6'd16;
  localparam logic [5:0] OpJmp     = 6'd17;
  localparam logic [5:0] OpJccBase = 6'd18;
  localparam logic [5:0] OpJccLast = 6'd25;
  localparam logic [5:0] OpAddBase = 6'd26;
  localparam logic [5:0] OpSubBase = 6'd32;
  localparam logic [5:0] OpMul     = 6'd38;
  localparam logic [5:0] OpDiv     = 6'd39;
  localparam logic [5:0] OpNot     = 6'd40;
  localparam logic [5:0] OpAndBase = 6'd41;
  localparam logic [5:0] OpOrBase  = 6'd47;

  // Operand forms inside each two-operand group.
  localparam logic [2:0] FormRegImm = 3'd0;
  localparam logic [2:0] FormRegReg = 3'd1;
  localparam logic [2:0] FormRegAbs = 3'd2;
  localparam logic [2:0] FormAbsReg = 3'd3;
  localparam logic [2:0] FormRegInd = 3'd4;
  localparam logic [2:0] FormIndReg = 3'd5;

  // Machine code constants.
  localparam logic [7:0] CodePush   = 8'h50;
  localparam logic [7:0] CodePop    = 8'h58;
  localparam logic [7:0] CodeMovImm = 8'hB8;
  localparam logic [7:0] CodeGrp1   = 8'h81;
  localparam logic [7:0] CodeGrp3   = 8'hF7;
  localparam logic [7:0] CodeJmp    = 8'hE9;
  localparam logic [7:0] CodeCall   = 8'hE8;
  localparam logic [7:0] CodeInt    = 8'hCD;
  localparam logic [7:0] CodeRet    = 8'hC3;
  localparam logic [7:0] ModRegReg  = 8'hC0;
  localparam logic [7:0] ModAbs     = 8'h05;

  // Register index 1..8 maps to 0..7; anything else maps to 0.
  function automatic logic [2:0] reg_code(input logic [31:0] r);
    logic ok;
    ok = (r >= 32'd1) && (r <= 32'd8);
    return ok ? 3'(r[2:0] - 3'd1) : 3'd0;
  endfunction

  // Store opcode of each two-operand group; the load opcode is two higher.
  function automatic logic [7:0] group_store(input logic [2:0] g);
    logic [7:0] code;
    unique case (g)
      3'd0:    code = 8'h89;
      3'd1:    code = 8'h39;
      3'd2:    code = 8'h01;
      3'd3:    code = 8'h29;
      3'd4:    code = 8'h21;
      default: code = 8'h09;
    endcase
    return code;
  endfunction

  // ModRM reg field extension of the 0x81 immediate form of each group.
  function automatic logic [2:0] group_ext(input logic [2:0] g);
    logic [2:0] e;
    unique case (g)
      3'd1:    e = 3'd7;
      3'd3:    e = 3'd5;
      3'd4:    e = 3'd4;
      3'd5:    e = 3'd1;
      default: e = 3'd0;
    endcase
    return e;
  endfunction

  // Short conditional jump opcodes: je jne jg jge jl jle jc jnc.
  function automatic logic [7:0] jcc_code(input logic [2:0] c);
    logic [7:0] code;
    unique case (c)
      3'd0:    code = 8'h74;
      3'd1:    code = 8'h75;
      3'd2:    code = 8'h7F;
      3'd3:    code = 8'h7D;
      3'd4:    code = 8'h7C;
      3'd5:    code = 8'h7E;
      3'd6:    code = 8'h72;
      default: code = 8'h73;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/x86_instruction_byte_encoder_top.sv =====
// Top level of the x86 instruction byte encoder: input register, origin
// register, encoder and byte serialiser. Depends on xibe_pkg, xibe_encode, xibe_serial.
//
// The block takes one resolved instruction per input transfer and produces its
// machine code as a stream of byte transfers in memory order, multi-byte values
// little-endian, each byte tagged with its output position (start_offset plus
// byte number, wrapping at 16 bits), an is_last flag on the final byte and an
// unknown_op flag for variant ids that have no encoding (these give a single
// zero byte). An instruction occupies the output for as many transfers as it
// has bytes, from one for push, pop, ret or an unknown id up to six for the
// immediate and absolute-address forms; with the output always ready the block
// sends the instructions with no gaps between them. An instruction is held in
// the input register, then the encoder output is loaded into the result buffer,
// which offers the first byte. The input register accepts the next instruction
// while the previous one is still being sent. Relative displacements for call,
// jmp and the short conditional jumps are taken against origin + start_offset +
// instruction length; the origin register resets to 0x20000 and is written
// through the configuration channel, which is always ready and must only be
// used while the block is idle.
module x86_instruction_byte_encoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  xibe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xibe_pkg::out_item_t out_data
);
  import xibe_pkg::*;

  logic [31:0] origin;
  logic        inq_valid;
  in_item_t    inq;
  enc_t        enc;
  logic        load;

  // The origin register takes every configuration transfer at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= 32'h0002_0000;
    end else if (cfg_valid) begin
      origin <= cfg_data;
    end
  end

  // The input register is free when empty or when its contents move on to the
  // result buffer in this cycle.
  assign in_ready = !inq_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_data;
    end
  end

  xibe_encode u_encode (
    .item   (inq),
    .origin (origin),
    .enc    (enc)
  );

  xibe_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (inq_valid),
    .enc       (enc),
    .load      (load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // An unknown variant id gives exactly one zero byte.
  a_unknown_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unknown_op |-> out_data.is_last && out_data.out_byte == 8'd0)
    else $error("unknown operation not sent as a single zero byte");

  // Bytes of one instruction follow each other at consecutive positions.
  a_next_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.is_last |=>
      out_valid && out_data.out_position == 16'($past(out_data.out_position) + 16'd1))
    else $error("instruction bytes not sent at consecutive positions");

  // A held instruction stays in the input register until the buffer takes it.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !load |=> inq_valid && $stable(inq))
    else $error("input register lost an instruction");
`endif

endmodule

// ===== hdl/xibe_encode.sv =====
// Combinational instruction encoder: turns one registered instruction into its
// machine code bytes and byte count. Depends on xibe_pkg.
module xibe_encode (
  input  xibe_pkg::in_item_t item,
  input  logic [31:0]        origin,
  output xibe_pkg::enc_t     enc
);
  import xibe_pkg::*;

  logic [2:0]  ra;
  logic [2:0]  rb;
  logic [31:0] base;
  logic [31:0] rel32;
  logic [7:0]  rel8;
  logic        in_group;
  logic [2:0]  grp;
  logic [5:0]  grp_base;
  logic [2:0]  form;
  logic [7:0]  st;
  logic [7:0]  ld;
  logic [5:0]  op;
  logic [5:0]  jcc_idx;

  assign op = item.operation;
  assign ra = reg_code(item.first_operand);
  assign rb = reg_code(item.second_operand);

  // Target minus the address of this instruction; the length is taken off below.
  assign base  = item.first_operand - origin - {16'd0, item.start_offset};
  assign rel32 = base - 32'd5;
  assign rel8  = 8'(base[7:0] - 8'd2);
  assign jcc_idx = op - OpJccBase;

  always_comb begin
    in_group = 1'b1;
    grp      = 3'd0;
    grp_base = OpMovBase;
    if (op >= OpMovBase && op < OpMovBase + 6'd6) begin
      grp = 3'd0; grp_base = OpMovBase;
    end else if (op >= OpCmpBase && op < OpCmpBase + 6'd6) begin
      grp = 3'd1; grp_base = OpCmpBase;
    end else if (op >= OpAddBase && op < OpAddBase + 6'd6) begin
      grp = 3'd2; grp_base = OpAddBase;
    end else if (op >= OpSubBase && op < OpSubBase + 6'd6) begin
      grp = 3'd3; grp_base = OpSubBase;
    end else if (op >= OpAndBase && op < OpAndBase + 6'd6) begin
      grp = 3'd4; grp_base = OpAndBase;
    end else if (op >= OpOrBase && op < OpOrBase + 6'd6) begin
      grp = 3'd5; grp_base = OpOrBase;
    end else begin
      in_group = 1'b0;
    end
  end

  assign form = 3'(op - grp_base);
  assign st   = group_store(grp);
  assign ld   = 8'(st + 8'd2);

  always_comb begin
    enc.bytes   = '0;
    enc.count   = 3'd0;
    enc.start   = item.start_offset;
    enc.unknown = 1'b0;
    priority if (op == OpPush || op == OpPop) begin
      enc.bytes[0] = 8'(((op == OpPush) ? CodePush : CodePop) + {5'd0, ra});
      enc.count    = 3'd1;
    end else if (op == OpRet) begin
      enc.bytes[0] = CodeRet;
      enc.count    = 3'd1;
    end else if (op == OpInt) begin
      enc.bytes[0] = CodeInt;
      enc.bytes[1] = item.first_operand[7:0];
      enc.count    = 3'd2;
    end else if (op == OpCall || op == OpJmp) begin
      enc.bytes[0]   = (op == OpCall) ? CodeCall : CodeJmp;
      enc.bytes[4:1] = rel32;
      enc.count      = 3'd5;
    end else if (op >= OpJccBase && op <= OpJccLast) begin
      enc.bytes[0] = jcc_code(jcc_idx[2:0]);
      enc.bytes[1] = rel8;
      enc.count    = 3'd2;
    end else if (op == OpMul || op == OpDiv || op == OpNot) begin
      enc.bytes[0] = CodeGrp3;
      enc.bytes[1] = ModRegReg | {2'b00,
                     (op == OpMul) ? 3'd4 : ((op == OpDiv) ? 3'd6 : 3'd2), ra};
      enc.count    = 3'd2;
    end else if (in_group) begin
      unique case (form)
        FormRegImm: begin
          if (grp == 3'd0) begin
            enc.bytes[0]   = 8'(CodeMovImm + {5'd0, ra});
            enc.bytes[4:1] = item.second_operand;
            enc.count      = 3'd5;
          end else begin
            enc.bytes[0]   = CodeGrp1;
            enc.bytes[1]   = ModRegReg | {2'b00, group_ext(grp), ra};
            enc.bytes[5:2] = item.second_operand;
            enc.count      = 3'd6;
          end
        end
        FormRegReg: begin
          enc.bytes[0] = st;
          enc.bytes[1] = ModRegReg | {2'b00, rb, ra};
          enc.count    = 3'd2;
        end
        FormRegAbs: begin
          enc.bytes[0]   = ld;
          enc.bytes[1]   = ModAbs | {2'b00, ra, 3'b000};
          enc.bytes[5:2] = item.second_operand;
          enc.count      = 3'd6;
        end
        FormAbsReg: begin
          enc.bytes[0]   = st;
          enc.bytes[1]   = ModAbs | {2'b00, rb, 3'b000};
          enc.bytes[5:2] = item.first_operand;
          enc.count      = 3'd6;
        end
        FormRegInd: begin
          enc.bytes[0] = ld;
          enc.bytes[1] = {2'b00, ra, rb};
          enc.count    = 3'd2;
        end
        default: begin
          enc.bytes[0] = st;
          enc.bytes[1] = {2'b00, rb, ra};
          enc.count    = 3'd2;
        end
      endcase
    end else begin
      // No encoding: a single zero byte flagged as unknown.
      enc.count   = 3'd1;
      enc.unknown = 1'b1;
    end
  end

endmodule

// ===== hdl/xibe_serial.sv =====
// Result buffer and byte serialiser: holds one encoded instruction and hands its
// bytes out one transfer at a time. Depends on xibe_pkg.
module xibe_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                enc_valid,
  input  xibe_pkg::enc_t      enc,
  output logic                load,
  output logic                out_valid,
  input  logic                out_ready,
  output xibe_pkg::out_item_t out_data
);
  import xibe_pkg::*;

  logic       held;
  enc_t       hold;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       last_byte;

  assign last_byte = (idx == 3'(hold.count - 3'd1));
  assign load      = enc_valid && (!held || (out_ready && last_byte));
  assign idx_next  = 3'(idx + 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= 3'd0;
    end else if (held && out_ready) begin
      if (last_byte) begin
        held <= 1'b0;
        idx  <= 3'd0;
      end else begin
        idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= enc;
    end
  end

  assign out_valid             = held;
  assign out_data.out_byte     = (idx < 3'(MaxBytes)) ? hold.bytes[idx] : 8'd0;
  assign out_data.out_position = 16'(hold.start + {13'd0, idx});
  assign out_data.is_last      = last_byte;
  assign out_data.unknown_op   = hold.unknown;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for x86_instruction_byte_encoder_top: directed and random instructions
// against an in-bench byte encoder, under several origin settings and idling patterns.
// Depends on xibe_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_top;
  import xibe_pkg::*;

  localparam logic [31:0] OriginAtReset = 32'h0002_0000;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned RandomPerPhase = 27;
  localparam int unsigned NumPhases     = 5;
  // Idle cycles let pass before a register write and before the final verdict.
  localparam int unsigned SettleCycles  = 6;

  // Register field extensions of the 0xF7 group and of the 0x81 group, per operation group.
  localparam logic [2:0] MulExt = 3'd4;
  localparam logic [2:0] DivExt = 3'd6;
  localparam logic [2:0] NotExt = 3'd2;
  localparam logic [5:0] GroupBase [6] = '{OpMovBase, OpCmpBase, OpAddBase,
                                           OpSubBase, OpAndBase, OpOrBase};
  localparam logic [7:0] GroupStoreCode [6] = '{8'h89, 8'h39, 8'h01, 8'h29, 8'h21, 8'h09};
  localparam logic [2:0] GroupImmExt [6] = '{3'd0, 3'd7, 3'd0, 3'd5, 3'd4, 3'd1};
  localparam logic [7:0] ShortJumpCode [8] = '{8'h74, 8'h75, 8'h7F, 8'h7D,
                                               8'h7C, 8'h7E, 8'h72, 8'h73};
  localparam logic [7:0] AbsModRm = ModAbs;

  typedef logic [MaxBytes-1:0][7:0] code_bytes_t;

  // Holds the bytes still owed by the block and checks each output transfer against them.
  class byte_scoreboard;
    logic [31:0] origin;
    out_item_t   owed_bytes[$];
    int unsigned failures;

    function new();
      origin   = OriginAtReset;
      failures = 0;
    endfunction

    function logic [2:0] reg_field(input logic [31:0] r);
      return (r >= 32'd1 && r <= 32'd8) ? 3'(r - 32'd1) : 3'd0;
    endfunction

    // Machine code of one instruction; returns the byte count, zero for an unknown id.
    function int unsigned build_code_bytes(input in_item_t it, output code_bytes_t b);
      logic [5:0]  op;
      logic [31:0] a, v, next_addr;
      logic [2:0]  ra, rb, ext, form;
      logic [7:0]  st, ld;
      int unsigned n;
      int          grp;
      op        = it.operation;
      a         = it.first_operand;
      v         = it.second_operand;
      ra        = reg_field(a);
      rb        = reg_field(v);
      next_addr = origin + 32'(it.start_offset);
      b         = '0;
      n         = 0;
      grp       = -1;
      for (int gi = 0; gi < 6; gi++) begin
        if (op >= GroupBase[gi] && op < GroupBase[gi] + 6'd6) grp = gi;
      end
      if (op == OpPush || op == OpPop) begin
        b[0] = (op == OpPush ? CodePush : CodePop) + 8'(ra);
        n = 1;
      end else if (op == OpRet) begin
        b[0] = CodeRet;
        n = 1;
      end else if (op == OpInt) begin
        b[0] = CodeInt;
        b[1] = a[7:0];
        n = 2;
      end else if (op == OpCall || op == OpJmp) begin
        b[0]   = (op == OpCall) ? CodeCall : CodeJmp;
        b[4:1] = a - (next_addr + 32'd5);
        n = 5;
      end else if (op >= OpJccBase && op <= OpJccLast) begin
        b[0] = ShortJumpCode[3'(op - OpJccBase)];
        b[1] = 8'(a - (next_addr + 32'd2));
        n = 2;
      end else if (op >= OpMul && op <= OpNot) begin
        ext  = (op == OpMul) ? MulExt : ((op == OpDiv) ? DivExt : NotExt);
        b[0] = CodeGrp3;
        b[1] = ModRegReg | {2'b00, ext, ra};
        n = 2;
      end else if (grp >= 0) begin
        form = 3'(op - GroupBase[grp]);
        st   = GroupStoreCode[grp];
        ld   = st + 8'd2;
        case (form)
          FormRegImm: begin
            if (grp == 0) begin
              b[0]   = CodeMovImm + 8'(ra);
              b[4:1] = v;
              n = 5;
            end else begin
              b[0]   = CodeGrp1;
              b[1]   = ModRegReg | {2'b00, GroupImmExt[grp], ra};
              b[5:2] = v;
              n = 6;
            end
          end
          FormRegReg: begin
            b[0] = st;
            b[1] = ModRegReg | {2'b00, rb, ra};
            n = 2;
          end
          FormRegAbs: begin
            b[0]   = ld;
            b[1]   = AbsModRm | {2'b00, ra, 3'b000};
            b[5:2] = v;
            n = 6;
          end
          FormAbsReg: begin
            b[0]   = st;
            b[1]   = AbsModRm | {2'b00, rb, 3'b000};
            b[5:2] = a;
            n = 6;
          end
          FormRegInd: begin
            b[0] = ld;
            b[1] = {2'b00, ra, rb};
            n = 2;
          end
          default: begin
            b[0] = st;
            b[1] = {2'b00, rb, ra};
            n = 2;
          end
        endcase
      end
      return n;
    endfunction

    function void note_instruction(input in_item_t it);
      code_bytes_t bytes;
      int unsigned n;
      out_item_t   e;
      n = build_code_bytes(it, bytes);
      if (n == 0) begin
        e = '{out_byte: 8'h00, out_position: it.start_offset, is_last: 1'b1, unknown_op: 1'b1};
        owed_bytes.push_back(e);
      end else begin
        for (int unsigned k = 0; k < n; k++) begin
          e.out_byte     = bytes[k];
          e.out_position = it.start_offset + 16'(k);
          e.is_last      = (k == n - 1);
          e.unknown_op   = 1'b0;
          owed_bytes.push_back(e);
        end
      end
    endfunction

    function void check_byte(input out_item_t got);
      out_item_t e;
      if (owed_bytes.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected byte transfer: byte %02h pos %04h last %0d unknown %0d",
                   got.out_byte, got.out_position, got.is_last, got.unknown_op);
        return;
      end
      e = owed_bytes.pop_front();
      if (got.out_byte !== e.out_byte || got.out_position !== e.out_position ||
          got.is_last !== e.is_last || got.unknown_op !== e.unknown_op) begin
        failures++;
        if (failures <= ReportLimit) begin
          $write("byte mismatch: expected byte %02h pos %04h last %0d unknown %0d, ",
                 e.out_byte, e.out_position, e.is_last, e.unknown_op);
          $display("got byte %02h pos %04h last %0d unknown %0d",
                   got.out_byte, got.out_position, got.is_last, got.unknown_op);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  byte_scoreboard sb = new();

  // Idling pattern of the current phase, in percent.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // The origin the block holds now, as the stimulus side sees it.
  logic [31:0] origin_now = OriginAtReset;
  int unsigned cycle_count = 0;

  x86_instruction_byte_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Inputs are known from time zero; after that every input changes only with a
  // nonblocking assignment at a rising edge, so the block samples them cleanly.
  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
  end

  // The receiver stalls on a random share of cycles set by the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every handshake is observed here, using the values that stood just before the
  // edge, so the order of processes within the time step does not matter. An
  // instruction never yields a byte at the edge of its own transfer, so noting
  // inputs first is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.origin = cfg_data;
      if (in_valid && in_ready) sb.note_instruction(in_data);
      if (out_valid && out_ready) sb.check_byte(out_data);
    end
  end

  // Watchdog: the limit is many times the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("x86_instruction_byte_encoder_top verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] r;
    case ($urandom_range(3))
      0, 1:    r = 32'($urandom_range(0, 9));
      2:       r = $urandom;
      default: r = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_instruction();
    in_item_t it;
    it.operation      = ($urandom_range(99) < 8) ? 6'($urandom_range(53, 63))
                                                 : 6'($urandom_range(0, 52));
    it.start_offset   = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFA, 16'hFFFF))
                                                 : 16'($urandom);
    it.first_operand  = random_operand();
    it.second_operand = random_operand();
    // Jump targets close to the instruction give short displacements in both directions.
    if ((it.operation == OpCall || it.operation == OpJmp ||
         (it.operation >= OpJccBase && it.operation <= OpJccLast)) && $urandom_range(1))
      it.first_operand = origin_now + 32'(it.start_offset) + 32'($urandom_range(0, 300)) - 32'd150;
    return it;
  endfunction

  function automatic in_item_t make_item(input logic [5:0] op, input logic [31:0] a,
                                         input logic [31:0] v, input logic [15:0] pos);
    in_item_t it;
    it.operation      = op;
    it.first_operand  = a;
    it.second_operand = v;
    it.start_offset   = pos;
    return it;
  endfunction

  // One input transfer. Each cycle before it is left idle with the phase's share,
  // so the sender idles in that share of its cycles; otherwise valid simply stays
  // high into the next instruction.
  task automatic send_instruction(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every owed byte has come out, then lets the block settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_origin(input logic [31:0] value);
    drain_block();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    origin_now = value;
  endtask

  task automatic send_directed();
    send_instruction(make_item(OpPush, 32'd0, 32'd0, 16'h0000));
    send_instruction(make_item(OpPush, 32'd8, 32'd3, 16'h0001));
    send_instruction(make_item(OpPush, 32'd9, 32'd0, 16'h0002));
    send_instruction(make_item(OpPop, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0003));
    send_instruction(make_item(OpPop, 32'd1, 32'd0, 16'h0004));
    send_instruction(make_item(OpRet, 32'd0, 32'd0, 16'h0005));
    send_instruction(make_item(OpInt, 32'h0000_01FF, 32'd0, 16'h0006));
    // Call forward and jmp whose displacement wraps through zero.
    send_instruction(make_item(OpCall, origin_now + 32'h100, 32'd0, 16'h0010));
    send_instruction(make_item(OpJmp, 32'd0, 32'd0, 16'hFFFF));
    // Short jumps forward, backward and far away, where the offset is truncated.
    send_instruction(make_item(OpJccBase, origin_now + 32'h40, 32'd0, 16'h0020));
    send_instruction(make_item(OpJccLast, origin_now + 32'h10, 32'd0, 16'h0030));
    send_instruction(make_item(OpJccBase + 6'd3, 32'h1234_5678, 32'd0, 16'h0040));
    send_instruction(make_item(OpMul, 32'd3, 32'd0, 16'h0050));
    send_instruction(make_item(OpDiv, 32'd8, 32'd0, 16'h0052));
    send_instruction(make_item(OpNot, 32'd5, 32'd0, 16'h0054));
    // Six-byte and five-byte forms across the position wrap.
    send_instruction(make_item(OpMovBase + FormRegImm, 32'd8, 32'hFFFF_FFFF, 16'hFFFC));
    send_instruction(make_item(OpAddBase + FormRegImm, 32'd2, 32'h8000_0001, 16'hFFFD));
    send_instruction(make_item(OpCmpBase + FormRegReg, 32'd8, 32'd1, 16'h0100));
    send_instruction(make_item(OpSubBase + FormRegAbs, 32'd7, 32'hCAFE_F00D, 16'h0200));
    send_instruction(make_item(OpAndBase + FormAbsReg, 32'hDEAD_BEEF, 32'd7, 16'h0300));
    send_instruction(make_item(OpOrBase + FormRegInd, 32'd6, 32'd9, 16'h0400));
    send_instruction(make_item(OpMovBase + FormIndReg, 32'd4, 32'd8, 16'h0500));
    send_instruction(make_item(6'd53, 32'd0, 32'd0, 16'h0600));
    send_instruction(make_item(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  // Phases: each sets its own idling and, after the first, its own origin.
  initial begin
    int unsigned send_pct [NumPhases];
    int unsigned recv_pct [NumPhases];
    logic [31:0] origins  [NumPhases];
    send_pct = '{0, 61, 0, 6, 0};
    recv_pct = '{0, 0, 61, 6, 0};
    origins  = '{OriginAtReset, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) write_origin(origins[p]);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) send_directed();
      repeat (RandomPerPhase) send_instruction(random_instruction());
    end

    drain_block();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("x86_instruction_byte_encoder_top verification clean");
    end else begin
      $display("x86_instruction_byte_encoder_top verification failed");
    end
    $finish;
  end

endmodule
